// ===== rtl/priority_ranked_register_log_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// priority ranked register log encoder: assertion macros
// shared property wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RANKED_REGISTER_LOG_ENCODER_DEFINES_SVH
`define PRIORITY_RANKED_REGISTER_LOG_ENCODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PRLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PRLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PRLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/prle_pkg.sv =====
// ----------------------------------------------------------------------------
// prle_pkg
// types and constants of the priority ranked register log encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prle_pkg;

    localparam int ACC_W = 34;

    localparam logic [7:0] SYNC_CODE  = 8'hff;
    localparam logic [8:0] BANK_LIMIT = 9'h0ff;

    localparam logic KIND_LOG = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // configuration register indexes
    localparam logic CFG_HOST_STEP = 1'b0;
    localparam logic CFG_SYNC_STEP = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_SCAN,
        S_COMMIT,
        S_SYNC
    } t_state;

    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        dev_id;
        logic [8:0]        reg_address;
        logic [7:0]        reg_data;
        logic signed [7:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [4:0] assigned_id;
        logic       status;
        logic       last;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/prle_cell.sv =====
// ----------------------------------------------------------------------------
// prle_cell
// one device slot: priority, rank and one stage of the rank count chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prle_cell
    import prle_pkg::*;
#(
    parameter int IDX = 0,
    parameter int RW  = 4,
    parameter int CW  = 5
) (
    input  wire               i_clk,
    input  wire signed [7:0]  i_prio_req,
    input  wire [CW-1:0]      i_count,
    input  wire [RW-1:0]      i_cnt,
    output logic [RW-1:0]     o_cnt,
    output logic [RW-1:0]     o_rank,
    input  wire               i_commit,
    input  wire [RW-1:0]      i_new_rank
);

    logic signed [7:0] r_prio;
    logic [RW-1:0]     r_rank;
    logic [RW-1:0]     r_cnt;
    logic              w_occupied;
    logic              w_ge;

    assign w_occupied = (i_count > CW'(IDX));
    assign w_ge       = w_occupied && (r_prio >= i_prio_req);

    // running count of this and earlier slots at or above the requested priority
    always_ff @(posedge i_clk) begin
        r_cnt <= i_cnt + RW'(w_ge);
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            if (i_count == CW'(IDX)) begin
                r_prio <= i_prio_req;
                r_rank <= i_new_rank;
            end else if (w_occupied && (r_rank >= i_new_rank)) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

    assign o_cnt  = r_cnt;
    assign o_rank = r_rank;

endmodule

`default_nettype wire

// ===== rtl/priority_ranked_register_log_encoder.sv =====
// ----------------------------------------------------------------------------
// priority_ranked_register_log_encoder
// turns device adds, register writes and host ticks into log byte and ack requests
// ----------------------------------------------------------------------------
// usage:
//   input requests (i_in_valid / o_in_stall / i_in) carry one action each;
//   result requests leave on o_out_valid / i_out_stall / o_out, none, one or
//   several per input, the final one flagged by last
//   a register write to a known id gives command, address and data bytes
//   one after another
//   an add walks the rank count through the chain of device cells, one cell a
//   cycle, and acks when the new rank is committed; a full table acks at once
//   with status set
//   a tick first accumulates, then gives sync bytes, up to MAX_SYNCS of them;
//   unknown writes and unused actions give nothing
//   one item is worked on at a time; the next is taken once the block is
//   idle and the output register is empty or being taken
//   host_step and sync_step are written through i_cfg_we; the user writes
//   them only while idle, and nothing in the block enforces this
//   reset clears the device count, accumulator, steps and output valid
//   a stall on the result side holds the output register and blocks input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "priority_ranked_register_log_encoder_defines.svh"

module priority_ranked_register_log_encoder
    import prle_pkg::*;
#(
    parameter int MAX_DEVICES = 16,
    parameter int MAX_SYNCS   = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [31:0]  i_cfg_data,
    // input requests
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    // result requests
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out        o_out
);

    localparam int RW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam int KW = $clog2(MAX_SYNCS + 1);

    // state and registers
    t_state              r_state, n_state;
    logic [31:0]         r_host_step;
    logic [31:0]         r_sync_step;
    logic [CW-1:0]       r_count, n_count;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic signed [7:0]   r_prio, n_prio;
    logic [RW-1:0]       r_scan, n_scan;
    logic [KW-1:0]       r_k, n_k;
    logic [7:0]          r_addr, n_addr;
    logic [7:0]          r_data, n_data;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    // datapath helpers
    logic                w_can_load;
    logic                w_accept;
    logic                w_load;
    logic                w_commit;
    logic [RW-1:0]       w_chain [MAX_DEVICES+1];
    logic [RW-1:0]       w_rank  [MAX_DEVICES];
    logic [MAX_DEVICES-1:0] w_hit;
    logic [RW-1:0]       w_sel_rank;
    logic                w_known;
    logic [7:0]          w_cmd;
    logic [ACC_W:0]      w_acc_sum;
    logic                w_sync_go;
    logic                w_sync_more;

    // output register frees when empty or being taken
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_can_load;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_commit   = (r_state == S_COMMIT) && w_can_load;

    // chain of device cells, the rank count ripples one cell per cycle
    assign w_chain[0] = '0;
    for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_cell
        prle_cell #(
            .IDX (g),
            .RW  (RW),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_prio_req (r_prio),
            .i_count    (r_count),
            .i_cnt      (w_chain[g]),
            .o_cnt      (w_chain[g+1]),
            .o_rank     (w_rank[g]),
            .i_commit   (w_commit),
            .i_new_rank (w_chain[MAX_DEVICES])
        );
        assign w_hit[g] = (int'(i_in.dev_id) == g) && (r_count > CW'(g));
    end

    // rank of the written device
    always_comb begin
        w_sel_rank = '0;
        for (int i = 0; i < MAX_DEVICES; i++) begin
            if (w_hit[i]) begin
                w_sel_rank = w_sel_rank | w_rank[i];
            end
        end
    end

    assign w_known = |w_hit;
    // back bank sets the low command bit
    assign w_cmd   = {7'(w_sel_rank), (i_in.reg_address > BANK_LIMIT)};

    // saturating accumulate
    assign w_acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_host_step);

    // sync while the accumulator exceeds one period; peek at a second period
    // so the byte can carry its last flag
    assign w_sync_go   = (r_sync_step != 32'd0) && (r_acc > ACC_W'(r_sync_step));
    assign w_sync_more = (r_acc > {1'b0, r_sync_step, 1'b0});

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_acc       = r_acc;
        n_prio      = r_prio;
        n_scan      = r_scan;
        n_k         = r_k;
        n_addr      = r_addr;
        n_data      = r_data;
        n_out       = r_out;
        w_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        ACT_ADD: begin
                            if (r_count == CW'(MAX_DEVICES)) begin
                                w_load            = 1'b1;
                                n_out.out_byte    = '0;
                                n_out.kind        = KIND_ACK;
                                n_out.assigned_id = '0;
                                n_out.status      = STATUS_FULL;
                                n_out.last        = 1'b1;
                            end else begin
                                n_prio  = i_in.priority_req;
                                n_scan  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_WRITE: begin
                            if (w_known) begin
                                w_load            = 1'b1;
                                n_out.out_byte    = w_cmd;
                                n_out.kind        = KIND_LOG;
                                n_out.assigned_id = '0;
                                n_out.status      = STATUS_OK;
                                n_out.last        = 1'b0;
                                n_addr            = i_in.reg_address[7:0];
                                n_data            = i_in.reg_data;
                                n_state           = S_ADDR;
                            end
                        end
                        ACT_TICK: begin
                            n_acc   = w_acc_sum[ACC_W] ? '1 : w_acc_sum[ACC_W-1:0];
                            n_k     = '0;
                            n_state = S_SYNC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADDR: begin
                if (w_can_load) begin
                    w_load         = 1'b1;
                    n_out.out_byte = r_addr;
                    n_out.last     = 1'b0;
                    n_state        = S_DATA;
                end
            end
            S_DATA: begin
                if (w_can_load) begin
                    w_load         = 1'b1;
                    n_out.out_byte = r_data;
                    n_out.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                // wait until the count has reached the end of the chain
                if (r_scan == RW'(MAX_DEVICES - 1)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_scan = r_scan + RW'(1);
                end
            end
            S_COMMIT: begin
                if (w_can_load) begin
                    w_load            = 1'b1;
                    n_out.out_byte    = '0;
                    n_out.kind        = KIND_ACK;
                    n_out.assigned_id = 5'(r_count);
                    n_out.status      = STATUS_OK;
                    n_out.last        = 1'b1;
                    n_count           = r_count + CW'(1);
                    n_state           = S_IDLE;
                end
            end
            S_SYNC: begin
                if (w_can_load) begin
                    if (w_sync_go) begin
                        w_load            = 1'b1;
                        n_acc             = r_acc - ACC_W'(r_sync_step);
                        n_out.out_byte    = SYNC_CODE;
                        n_out.kind        = KIND_LOG;
                        n_out.assigned_id = '0;
                        n_out.status      = STATUS_OK;
                        n_out.last        = (r_k == KW'(MAX_SYNCS - 1)) || !w_sync_more;
                        n_k               = r_k + KW'(1);
                        if (n_out.last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            r_scan      <= n_scan;
            r_k         <= n_k;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_step <= '0;
            r_sync_step <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOST_STEP: r_host_step <= i_cfg_data;
                CFG_SYNC_STEP: r_sync_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_addr <= n_addr;
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an add commit grows the table by exactly one
    `PRLE_ASSERT_NXT(a_commit_count, i_clk, i_rst_n, w_commit, r_count == $past(r_count) + CW'(1), "device count did not step on commit")
    // a request flagged last hands control back to idle
    `PRLE_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, w_load && n_out.last, r_state == S_IDLE, "last request did not return to idle")
    // the sync cap always closes the burst
    `PRLE_ASSERT_IMP(a_sync_cap, i_clk, i_rst_n, w_load && (r_state == S_SYNC) && (r_k == KW'(MAX_SYNCS - 1)), n_out.last, "sync burst ran past its cap")
    // syncing only ever drains the accumulator
    `PRLE_ASSERT_NXT(a_sync_drain, i_clk, i_rst_n, r_state == S_SYNC, r_acc <= $past(r_acc), "accumulator grew while syncing")
    // the table never holds more devices than slots
    `PRLE_ASSERT_IMP(a_count_range, i_clk, i_rst_n, r_state == S_COMMIT, r_count < CW'(MAX_DEVICES), "add commit with a full table")

endmodule

`default_nettype wire

// ===== bench/priority_ranked_register_log_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// priority ranked register log encoder checker
// watches the config port and both request channels, keeps its own copy of
// the device table, step registers and time accumulator, works out the log
// bytes and add acks that each accepted input request must cause, and
// compares every accepted result request against the oldest one still due
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ranked_register_log_encoder_checker
    import prle_pkg::*;
#(
    parameter int MAX_DEVICES = 16,
    parameter int MAX_SYNCS   = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  t_in         i_in,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  t_out        i_out,
    output int          o_log_errors,
    output int          o_log_due
);

    localparam logic [ACC_W:0] ACC_LIMIT = {1'b0, {ACC_W{1'b1}}};

    logic [31:0]       host_step_q;
    logic [31:0]       sync_step_q;
    logic signed [7:0] device_priority [MAX_DEVICES];
    int unsigned       device_rank [MAX_DEVICES];
    int unsigned       device_count;
    logic [ACC_W-1:0]  time_acc;
    t_out              upcoming_log [$];

    function automatic void queue_log(input logic [7:0] value, input logic kind,
                                      input logic [4:0] id, input logic status,
                                      input logic last);
        t_out item;
        item.out_byte    = value;
        item.kind        = kind;
        item.assigned_id = id;
        item.status      = status;
        item.last        = last;
        upcoming_log.push_back(item);
    endfunction

    function automatic void encode_request(input t_in req);
        int unsigned      rank;
        int unsigned      cmd;
        int               syncs;
        logic [ACC_W:0]   total;
        case (req.action)
            ACT_ADD: begin
                if (device_count >= MAX_DEVICES) begin
                    // table full: nothing changes, ack flags it
                    queue_log(8'h00, KIND_ACK, 5'd0, STATUS_FULL, 1'b1);
                end else begin
                    rank = 0;
                    for (int i = 0; i < device_count; i++)
                        if ($signed(device_priority[i]) >= $signed(req.priority_req))
                            rank++;
                    for (int i = 0; i < device_count; i++)
                        if (device_rank[i] >= rank)
                            device_rank[i]++;
                    device_priority[device_count] = req.priority_req;
                    device_rank[device_count]     = rank;
                    queue_log(8'h00, KIND_ACK, device_count[4:0], STATUS_OK, 1'b1);
                    device_count++;
                end
            end
            ACT_WRITE: begin
                // unknown ids are dropped silently
                if (req.dev_id < device_count) begin
                    cmd = device_rank[req.dev_id] * 2
                        + ((req.reg_address > BANK_LIMIT) ? 1 : 0);
                    queue_log(cmd[7:0], KIND_LOG, 5'd0, STATUS_OK, 1'b0);
                    queue_log(req.reg_address[7:0], KIND_LOG, 5'd0, STATUS_OK, 1'b0);
                    queue_log(req.reg_data, KIND_LOG, 5'd0, STATUS_OK, 1'b1);
                end
            end
            ACT_TICK: begin
                total = {1'b0, time_acc} + host_step_q;
                if (total > ACC_LIMIT)
                    total = ACC_LIMIT;
                time_acc = total[ACC_W-1:0];
                syncs = 0;
                if (sync_step_q != 0)
                    while (syncs < MAX_SYNCS && time_acc > sync_step_q) begin
                        time_acc = time_acc - sync_step_q;
                        syncs++;
                    end
                for (int k = 0; k < syncs; k++)
                    queue_log(SYNC_CODE, KIND_LOG, 5'd0, STATUS_OK, k == syncs - 1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out due;
        if (!i_rst_n) begin
            host_step_q  = '0;
            sync_step_q  = '0;
            device_count = 0;
            time_acc     = '0;
            upcoming_log.delete();
            o_log_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HOST_STEP)
                    host_step_q = i_cfg_data;
                else
                    sync_step_q = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (upcoming_log.size() == 0) begin
                    if (o_log_errors < 10)
                        $display("%0t: unexpected result byte %02h kind %0d id %0d status %0d last %0d",
                                 $time, i_out.out_byte, i_out.kind, i_out.assigned_id,
                                 i_out.status, i_out.last);
                    o_log_errors++;
                end else begin
                    due = upcoming_log.pop_front();
                    if (i_out.out_byte !== due.out_byte || i_out.kind !== due.kind ||
                        i_out.assigned_id !== due.assigned_id ||
                        i_out.status !== due.status || i_out.last !== due.last) begin
                        if (o_log_errors < 10)
                            $display("%0t: result mismatch: expected byte %02h kind %0d id %0d status %0d last %0d, got byte %02h kind %0d id %0d status %0d last %0d",
                                     $time, due.out_byte, due.kind, due.assigned_id,
                                     due.status, due.last, i_out.out_byte, i_out.kind,
                                     i_out.assigned_id, i_out.status, i_out.last);
                        o_log_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                encode_request(i_in);
        end
        o_log_due = upcoming_log.size();
    end

endmodule

// ===== bench/priority_ranked_register_log_encoder_test.sv =====
// ----------------------------------------------------------------------------
// priority ranked register log encoder test
// drives device adds, register writes, host ticks and unused actions into the
// encoder under several step settings, with random input gaps and result-side
// stalls; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_ranked_register_log_encoder_test;
    import prle_pkg::*;

    localparam int MAX_DEVICES    = 16;
    localparam int MAX_SYNCS      = 8;
    localparam int PHASES         = 7;
    localparam int RANDOM_ITEMS   = 189;
    // an add walks every device cell, the slowest item in the block
    localparam int SETTLE_CYCLES  = MAX_DEVICES + 8;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    t_in         in_req;
    logic        out_valid;
    logic        out_stall;
    t_out        out_rsp;

    int          log_errors;
    int          log_due;
    int          idle_cycles;
    int          devices_added;

    // knobs set by the request source; the result sink reads the last two
    bit          gaps_on;
    bit          sink_quiet;
    bit          hold_request;

    priority_ranked_register_log_encoder #(
        .MAX_DEVICES (MAX_DEVICES),
        .MAX_SYNCS   (MAX_SYNCS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp)
    );

    priority_ranked_register_log_encoder_checker #(
        .MAX_DEVICES (MAX_DEVICES),
        .MAX_SYNCS   (MAX_SYNCS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_rsp),
        .o_log_errors (log_errors),
        .o_log_due    (log_due)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: any accepted request on either side restarts the count
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // every field random, so unused fields toggle too
    function automatic t_in random_request();
        t_in req;
        req.action       = 2'($urandom_range(0, 3));
        req.dev_id       = 4'($urandom_range(0, 15));
        req.reg_address  = 9'($urandom_range(0, 511));
        req.reg_data     = 8'($urandom_range(0, 255));
        req.priority_req = 8'($urandom_range(0, 255));
        return req;
    endfunction

    function automatic t_in make_add(input logic signed [7:0] prio);
        t_in req;
        req              = random_request();
        req.action       = ACT_ADD;
        req.priority_req = prio;
        return req;
    endfunction

    function automatic t_in make_write(input logic [3:0] id, input logic [8:0] addr,
                                       input logic [7:0] value);
        t_in req;
        req             = random_request();
        req.action      = ACT_WRITE;
        req.dev_id      = id;
        req.reg_address = addr;
        req.reg_data    = value;
        return req;
    endfunction

    function automatic t_in make_other(input t_action act);
        t_in req;
        req        = random_request();
        req.action = act;
        return req;
    endfunction

    // priorities that collide often, so equal-priority ranking gets exercised
    function automatic logic signed [7:0] pick_priority();
        case ($urandom_range(0, 9))
            0:       return 8'sd0;
            1:       return 8'sd1;
            2:       return -8'sd1;
            3:       return 8'sd127;
            4:       return -8'sd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly writes to devices that exist, some adds and ticks, a little noise
    function automatic t_in pick_request();
        int unsigned roll;
        int unsigned known;
        roll  = $urandom_range(0, 99);
        known = (devices_added > MAX_DEVICES) ? MAX_DEVICES : devices_added;
        if (roll < 10)
            return make_add(pick_priority());
        if (roll < 55 && known > 0)
            return make_write(4'($urandom_range(0, known - 1)),
                              9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        if (roll < 62)
            return make_other(ACT_WRITE);
        if (roll < 95)
            return make_other(ACT_TICK);
        return make_other(ACT_NONE);
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input t_in req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_req   = req;
        do @(posedge clk); while (in_stall);
        if (req.action == ACT_ADD)
            devices_added++;
    endtask

    // stop offering until every predicted result has come out, then let the
    // block finish anything that gives no result
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (log_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // result sink: random stalls, quiet stretches and one long hold-off
    initial begin : result_sink
        int unsigned roll;
        int          burst;
        out_stall = 1'b0;
        burst     = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                // block input side stalls while results are held back
                hold_request = 1'b0;
                out_stall    = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall    = 1'b0;
            end else if (sink_quiet) begin
                out_stall = 1'b0;
                burst     = 0;
            end else if (burst > 0) begin
                out_stall = 1'b1;
                burst--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    out_stall = 1'b0;
                end else begin
                    out_stall = 1'b1;
                    burst     = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    // request source and verdict
    initial begin : request_source
        logic [31:0] host_step;
        logic [31:0] sync_step;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_HOST_STEP;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_req        = '0;
        gaps_on       = 1'b1;
        sink_quiet    = 1'b0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        devices_added = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_register(CFG_HOST_STEP, 32'd0);
        write_register(CFG_SYNC_STEP, 32'd0);

        // empty table: writes go nowhere, unused action and quiet tick
        send_request(make_write(4'd0, 9'h000, 8'h11));
        send_request(make_other(ACT_NONE));
        send_request(make_other(ACT_TICK));

        // ranking: extreme priorities and an equal-priority tie
        send_request(make_add(8'sd0));
        send_request(make_add(8'sd127));
        send_request(make_add(-8'sd128));
        send_request(make_add(8'sd0));

        // both banks, address and data extremes, then ids past the table
        send_request(make_write(4'd0, 9'h000, 8'h00));
        send_request(make_write(4'd1, 9'h1ff, 8'hff));
        send_request(make_write(4'd2, 9'h100, 8'h5a));
        send_request(make_write(4'd3, 9'h0ff, 8'ha5));
        send_request(make_write(4'd4, 9'h0ff, 8'h00));
        send_request(make_write(4'd15, 9'h1ff, 8'hff));

        // no sync period: accumulator runs into saturation without syncs
        wait_drained();
        write_register(CFG_HOST_STEP, 32'hffff_ffff);
        repeat (5) send_request(make_other(ACT_TICK));

        // tiny period on a saturated accumulator: every tick hits the sync cap
        wait_drained();
        write_register(CFG_HOST_STEP, 32'd0);
        write_register(CFG_SYNC_STEP, 32'd1);
        repeat (2) send_request(make_other(ACT_TICK));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin host_step = 32'hffff_ffff; sync_step = 32'd0;        end
                1: begin host_step = 32'd0;         sync_step = 32'd1;        end
                // 16667 us at denom 1000
                2: begin host_step = 32'd16667000;  sync_step = 32'd16000000; end
                3: begin host_step = 32'hffff_ffff; sync_step = 32'hffff_ffff; end
                4: begin host_step = 32'd3000;      sync_step = 32'd1000;     end
                5: begin host_step = 32'd1000;      sync_step = 32'd2500;     end
                default: begin
                    host_step = $urandom_range(1, 5000);
                    sync_step = $urandom_range(0, 2000);
                end
            endcase
            write_register(CFG_HOST_STEP, host_step);
            write_register(CFG_SYNC_STEP, sync_step);
            // one phase runs back to back with no input gaps and no result stalls
            gaps_on    = (phase != 4);
            sink_quiet = (phase == 4);
            if (phase == 2)
                hold_request = 1'b1;
            repeat (RANDOM_ITEMS / PHASES) send_request(pick_request());
        end

        // make sure a full table gets hit at least once
        while (devices_added <= MAX_DEVICES)
            send_request(make_add(pick_priority()));

        wait_drained();
        if (log_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== priority_ranked_register_log_encoder.f =====
+incdir+rtl
rtl/prle_pkg.sv
rtl/prle_cell.sv
rtl/priority_ranked_register_log_encoder.sv
bench/priority_ranked_register_log_encoder_checker.sv
bench/priority_ranked_register_log_encoder_test.sv
